// ===== src/fatseg_pkg.sv =====
// Package for the FAT16 file read segmenter.
// Holds shared codes, constants and the request/response types of the shared unit.
// No dependencies.
`default_nettype none

package fatseg_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_OPEN = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Status codes of a result beat.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_EOF      = 2'd2;
  localparam logic [1:0] ST_CHAIN    = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SECTOR_LOG2  = 3'd0;
  localparam logic [2:0] CFG_CLUSTER_LOG2 = 3'd1;
  localparam logic [2:0] CFG_RESERVED     = 3'd2;
  localparam logic [2:0] CFG_FAT_COPIES   = 3'd3;
  localparam logic [2:0] CFG_FAT_SECTORS  = 3'd4;
  localparam logic [2:0] CFG_ROOT_SECTORS = 3'd5;

  localparam logic [15:0] EOC_MARK = 16'hFFF8;
  localparam logic [15:0] FAT_OOR  = 16'hFFFF;
  localparam logic [7:0]  ATTR_DIR = 8'h10;
  localparam logic [7:0]  ATTR_VOL = 8'h08;

  localparam logic [3:0] SEC_LOG2_MIN  = 4'd9;
  localparam logic [3:0] SEC_LOG2_MAX  = 4'd12;
  localparam logic [4:0] CLUS_LOG2_MAX = 5'd16;

  // One operation of the shared shift-add unit: (a << shamt) + b, or minus b.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [3:0]  shamt;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] result;
    logic        carry;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== src/fatseg_in_if.sv =====
// Input channel of the FAT16 file read segmenter: valid, ready and one item.
// No dependencies.
`default_nettype none

interface fatseg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] fat_index;
  logic [15:0] fat_value;
  logic [15:0] start_cluster;
  logic [31:0] file_size;
  logic [7:0]  entry_attributes;
  logic [15:0] read_length;
  logic [15:0] buffer_limit;

  modport source (
    output valid, operation, fat_index, fat_value, start_cluster, file_size,
           entry_attributes, read_length, buffer_limit,
    input  ready
  );
  modport sink (
    input  valid, operation, fat_index, fat_value, start_cluster, file_size,
           entry_attributes, read_length, buffer_limit,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/fatseg_out_if.sv =====
// Result channel of the FAT16 file read segmenter: valid, ready and one segment.
// No dependencies.
`default_nettype none

interface fatseg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] disk_address;
  logic [16:0] segment_length;
  logic [15:0] buffer_offset;
  logic [15:0] bytes_done;
  logic [1:0]  status;
  logic        last;

  modport source (
    output valid, disk_address, segment_length, buffer_offset, bytes_done, status, last,
    input  ready
  );
  modport sink (
    input  valid, disk_address, segment_length, buffer_offset, bytes_done, status, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/fatseg_alu.sv =====
// Shared 32-bit shift-add unit of the segmenter.
// Depends on fatseg_pkg for the request and response types.
`default_nettype none

module fatseg_alu
  import fatseg_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [31:0] shifted;
  logic [31:0] b_op;
  logic [32:0] sum;

  assign shifted = req.a << req.shamt;
  assign b_op    = req.b ^ {32{req.sub}};
  assign sum     = {1'b0, shifted} + {1'b0, b_op} + {32'd0, req.sub};

  assign rsp.result = sum[31:0];
  assign rsp.carry  = sum[32];

endmodule

`default_nettype wire

// ===== src/fatseg_fat_mem.sv =====
// FAT word store: one write port and one read port with registered read data.
// Depends on nothing; the entry count comes from the top level.
`default_nettype none

module fatseg_fat_mem #(
  parameter int ENTRIES = 4096,
  parameter int AW      = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [ENTRIES];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/fat16_file_read_segmenter.sv =====
// Top level of the FAT16 file read segmenter: sequencer, file state and config registers.
// Depends on fatseg_pkg, fatseg_in_if, fatseg_out_if, fatseg_alu and fatseg_fat_mem.
//
//   channel   direction  handshake          carries
//   in_chan   sink       valid/ready        load, open or read item
//   out_chan  source     valid/ready        one disk segment or one status beat
//   cfg_*     input      cfg_we, no ready   volume geometry registers
//
// A load beat goes straight to the FAT store. An open beat posts its result beat from
// S_ONE; a read that ends before walking the chain posts it from S_ONE after RD_REM.
// A read runs three setup steps, then four steps per segment, set by the shared
// shift-add unit, which computes three address steps and the position update.
// Reset is synchronous and active low; it closes the file, restores the config
// registers and empties the output register. The FAT store is not cleared.
// When the output register still holds an untaken beat, the sequencer holds
// in its emit step until the beat leaves.
`default_nettype none

module fat16_file_read_segmenter
  import fatseg_pkg::*;
#(
  parameter int FAT_ENTRIES  = 4096,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  fatseg_in_if.sink          in_chan,
  fatseg_out_if.source       out_chan,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int AW = $clog2(FAT_ENTRIES);
  localparam int KW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [16:0]   FAT_LIMIT = 17'(FAT_ENTRIES);
  localparam logic [KW-1:0] K_LAST    = KW'(MAX_SEGMENTS - 1);

  // The sequencer. A read runs RD_REM, RD_BASE1, RD_BASE2 once and then loops
  // over SG_CL, SG_SH1, SG_SH2 and SG_POS for each segment.
  typedef enum logic [3:0] {
    S_IDLE, S_ONE, RD_REM, RD_BASE1, RD_BASE2, SG_CL, SG_SH1, SG_SH2, SG_POS
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [3:0]  sec_log2_r;
  logic [2:0]  clus_log2_r;
  logic [15:0] rsv_r;
  logic [2:0]  copies_r;
  logic [15:0] fatsec_r;
  logic [15:0] root_r;

  // Open file state.
  logic        open_r, open_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] size_r, size_nxt;

  // Read working registers.
  logic [15:0]   req_r, req_nxt;
  logic [15:0]   lim_r, lim_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [15:0]   done_r, done_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [31:0]   base_r, base_nxt;
  logic [15:0]   off_r, off_nxt;
  logic [16:0]   seg_r, seg_nxt;
  logic          oor_r, oor_nxt;
  logic [1:0]    one_st_r, one_st_nxt;

  // Output register.
  logic        ov_r, ov_nxt;
  logic [31:0] o_addr_r, o_addr_nxt;
  logic [16:0] o_len_r, o_len_nxt;
  logic [15:0] o_boff_r, o_boff_nxt;
  logic [15:0] o_done_r, o_done_nxt;
  logic [1:0]  o_st_r, o_st_nxt;
  logic        o_last_r, o_last_nxt;

  // Cluster geometry, derived from the config registers. The sector size is
  // saturated into 512..4096 bytes and the cluster size is capped at 64 KiB.
  logic [3:0]  s_eff;
  logic [4:0]  cl2_raw;
  logic [4:0]  cl2;
  logic [2:0]  cs_eff;
  logic [16:0] csize;
  logic [15:0] cmask;
  logic [18:0] fat_prod;

  always_comb begin
    if (sec_log2_r < SEC_LOG2_MIN) begin
      s_eff = SEC_LOG2_MIN;
    end else if (sec_log2_r > SEC_LOG2_MAX) begin
      s_eff = SEC_LOG2_MAX;
    end else begin
      s_eff = sec_log2_r;
    end
    cl2_raw = {1'b0, s_eff} + {2'b00, clus_log2_r};
    cl2     = (cl2_raw > CLUS_LOG2_MAX) ? CLUS_LOG2_MAX : cl2_raw;
    cs_eff  = 3'(cl2 - {1'b0, s_eff});
    csize   = 17'd1 << cl2;
    cmask   = 16'(csize - 17'd1);
  end

  assign fat_prod = 19'(copies_r) * 19'(fatsec_r);

  // Shared shift-add unit.
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  fatseg_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // FAT store.
  logic          mem_we;
  logic          mem_re;
  logic [15:0]   fat_rdata;

  fatseg_fat_mem #(
    .ENTRIES (FAT_ENTRIES),
    .AW      (AW)
  ) u_fat_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_chan.fat_index)),
    .wdata (in_chan.fat_value),
    .re    (mem_re),
    .raddr (AW'(cur_r)),
    .rdata (fat_rdata)
  );

  // Handshake terms.
  logic in_fire;
  logic out_free;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !ov_r || out_chan.ready;

  // Per-read and per-segment values that feed the sequencer.
  logic        at_eof;
  logic [15:0] min_rl;
  logic [15:0] len_clip;
  logic [15:0] seg_off;
  logic [16:0] seg_full;
  logic [15:0] rem;
  logic [16:0] seg_cut;
  logic [15:0] next_cl;
  logic [15:0] done_plus;
  logic        boundary;
  logic        chain_end;
  logic        seg_last;

  always_comb begin
    // Read setup: bytes left in the file come from the shared unit; the
    // carry is set when the size is at least the position.
    at_eof   = !open_r || !alu_rsp.carry || (alu_rsp.result == 32'd0);
    min_rl   = (req_r < lim_r) ? req_r : lim_r;
    len_clip = (alu_rsp.result < {16'd0, min_rl}) ? alu_rsp.result[15:0] : min_rl;

    // Segment size: to the end of the cluster, or to the end of the read.
    seg_off  = pos_r[15:0] & cmask;
    seg_full = csize - {1'b0, seg_off};
    rem      = len_r - done_r;
    seg_cut  = (seg_full > {1'b0, rem}) ? {1'b0, rem} : seg_full;

    // Emit step: the shared unit is adding the segment to the position.
    next_cl   = oor_r ? FAT_OOR : fat_rdata;
    done_plus = done_r + seg_r[15:0];
    boundary  = (alu_rsp.result[15:0] & cmask) == 16'd0;
    chain_end = boundary && (next_cl >= EOC_MARK) && (done_plus != len_r);
    seg_last  = chain_end || (done_plus == len_r) || (k_r == K_LAST);
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      RD_REM: begin
        alu_req.a   = size_r;
        alu_req.b   = pos_r;
        alu_req.sub = 1'b1;
      end
      RD_BASE1: begin
        alu_req.a = {16'd0, rsv_r};
        alu_req.b = {16'd0, root_r};
      end
      RD_BASE2: begin
        alu_req.a = {13'd0, fat_prod};
        alu_req.b = acc_r;
      end
      SG_CL: begin
        alu_req.a   = {16'd0, cur_r};
        alu_req.b   = 32'd2;
        alu_req.sub = 1'b1;
      end
      SG_SH1: begin
        alu_req.a     = acc_r;
        alu_req.b     = base_r;
        alu_req.shamt = {1'b0, cs_eff};
      end
      SG_SH2: begin
        alu_req.a     = acc_r;
        alu_req.b     = {16'd0, off_r};
        alu_req.shamt = s_eff;
      end
      SG_POS: begin
        alu_req.a = pos_r;
        alu_req.b = {15'd0, seg_r};
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // A load writes only inside the table; a chain read past it gives all ones.
  assign mem_we = in_fire && (in_chan.operation == OP_LOAD)
                  && ({5'd0, in_chan.fat_index} < FAT_LIMIT);
  assign mem_re = (state_r == SG_CL);

  // Sequencer next state.
  always_comb begin
    state_nxt  = state_r;
    open_nxt   = open_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    size_nxt   = size_r;
    req_nxt    = req_r;
    lim_nxt    = lim_r;
    len_nxt    = len_r;
    done_nxt   = done_r;
    k_nxt      = k_r;
    acc_nxt    = acc_r;
    base_nxt   = base_r;
    off_nxt    = off_r;
    seg_nxt    = seg_r;
    oor_nxt    = oor_r;
    one_st_nxt = one_st_r;
    ov_nxt     = ov_r && !out_chan.ready;
    o_addr_nxt = o_addr_r;
    o_len_nxt  = o_len_r;
    o_boff_nxt = o_boff_r;
    o_done_nxt = o_done_r;
    o_st_nxt   = o_st_r;
    o_last_nxt = o_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_chan.operation)
            OP_OPEN: begin
              pos_nxt   = 32'd0;
              state_nxt = S_ONE;
              if ((in_chan.entry_attributes & (ATTR_DIR | ATTR_VOL)) != 8'd0) begin
                // Directories and volume labels close any open file.
                open_nxt   = 1'b0;
                cur_nxt    = 16'd0;
                size_nxt   = 32'd0;
                one_st_nxt = ST_REJECTED;
              end else begin
                open_nxt   = 1'b1;
                cur_nxt    = in_chan.start_cluster;
                size_nxt   = in_chan.file_size;
                one_st_nxt = ST_OK;
              end
            end
            OP_READ: begin
              req_nxt   = in_chan.read_length;
              lim_nxt   = in_chan.buffer_limit;
              state_nxt = RD_REM;
            end
            default: begin
              // A load goes straight to the store; an unknown code does nothing.
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ONE: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_addr_nxt = 32'd0;
          o_len_nxt  = 17'd0;
          o_boff_nxt = 16'd0;
          o_done_nxt = 16'd0;
          o_st_nxt   = one_st_r;
          o_last_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      RD_REM: begin
        len_nxt  = len_clip;
        done_nxt = 16'd0;
        k_nxt    = '0;
        if (at_eof) begin
          one_st_nxt = ST_EOF;
          state_nxt  = S_ONE;
        end else if (len_clip == 16'd0) begin
          one_st_nxt = ST_OK;
          state_nxt  = S_ONE;
        end else if (cur_r >= EOC_MARK) begin
          one_st_nxt = ST_CHAIN;
          state_nxt  = S_ONE;
        end else begin
          state_nxt = RD_BASE1;
        end
      end

      RD_BASE1: begin
        acc_nxt   = alu_rsp.result;
        state_nxt = RD_BASE2;
      end

      RD_BASE2: begin
        base_nxt  = alu_rsp.result;
        state_nxt = SG_CL;
      end

      SG_CL: begin
        // The FAT read of the current cluster is issued here as well.
        acc_nxt   = alu_rsp.result;
        off_nxt   = seg_off;
        seg_nxt   = seg_cut;
        oor_nxt   = ({1'b0, cur_r} >= FAT_LIMIT);
        state_nxt = SG_SH1;
      end

      SG_SH1: begin
        acc_nxt   = alu_rsp.result;
        state_nxt = SG_SH2;
      end

      SG_SH2: begin
        acc_nxt   = alu_rsp.result;
        state_nxt = SG_POS;
      end

      SG_POS: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_addr_nxt = acc_r;
          o_len_nxt  = seg_r;
          o_boff_nxt = done_r;
          o_done_nxt = done_plus;
          o_st_nxt   = chain_end ? ST_CHAIN : ST_OK;
          o_last_nxt = seg_last;
          pos_nxt    = alu_rsp.result;
          if (boundary) begin
            cur_nxt = next_cl;
          end
          done_nxt  = done_plus;
          k_nxt     = k_r + KW'(1);
          state_nxt = seg_last ? S_IDLE : SG_CL;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      open_r  <= 1'b0;
      cur_r   <= 16'd0;
      pos_r   <= 32'd0;
      size_r  <= 32'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      open_r   <= open_nxt;
      cur_r    <= cur_nxt;
      pos_r    <= pos_nxt;
      size_r   <= size_nxt;
      ov_r     <= ov_nxt;
      req_r    <= req_nxt;
      lim_r    <= lim_nxt;
      len_r    <= len_nxt;
      done_r   <= done_nxt;
      k_r      <= k_nxt;
      acc_r    <= acc_nxt;
      base_r   <= base_nxt;
      off_r    <= off_nxt;
      seg_r    <= seg_nxt;
      oor_r    <= oor_nxt;
      one_st_r <= one_st_nxt;
      o_addr_r <= o_addr_nxt;
      o_len_r  <= o_len_nxt;
      o_boff_r <= o_boff_nxt;
      o_done_r <= o_done_nxt;
      o_st_r   <= o_st_nxt;
      o_last_r <= o_last_nxt;
    end
  end

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_log2_r  <= 4'd9;
      clus_log2_r <= 3'd0;
      rsv_r       <= 16'd1;
      copies_r    <= 3'd2;
      fatsec_r    <= 16'd1;
      root_r      <= 16'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SECTOR_LOG2:  sec_log2_r  <= cfg_wdata[3:0];
        CFG_CLUSTER_LOG2: clus_log2_r <= cfg_wdata[2:0];
        CFG_RESERVED:     rsv_r       <= cfg_wdata;
        CFG_FAT_COPIES:   copies_r    <= cfg_wdata[2:0];
        CFG_FAT_SECTORS:  fatsec_r    <= cfg_wdata;
        CFG_ROOT_SECTORS: root_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_chan.valid          = ov_r;
  assign out_chan.disk_address   = o_addr_r;
  assign out_chan.segment_length = o_len_r;
  assign out_chan.buffer_offset  = o_boff_r;
  assign out_chan.bytes_done     = o_done_r;
  assign out_chan.status         = o_st_r;
  assign out_chan.last           = o_last_r;

  // Every posted beat covers exactly its own bytes after its buffer offset.
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |->
      out_chan.bytes_done == 16'(out_chan.buffer_offset + out_chan.segment_length[15:0]))
    else $error("bytes_done does not match buffer_offset plus segment_length");

  // Reads are clipped to the file, so the position never passes the size.
  a_pos_in_file: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && open_r) |-> pos_r <= size_r)
    else $error("file position passed the file size");

  // The segment that carries last returns the sequencer to idle.
  a_last_ends_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SG_POS && out_free && seg_last) |=> state_r == S_IDLE)
    else $error("sequencer kept walking after the last segment");

endmodule

`default_nettype wire
